>>> rtl/dpgp_pkg.sv
// ----------------------------------------------------------------------------
// dpgp_pkg
// shared types, widths and the cordic arctangent table
// ----------------------------------------------------------------------------
package dpgp_pkg;

    localparam int NUM_W  = 35;   // dividend width (scaled magnitude >> 16)
    localparam int FWD_W  = 15;
    localparam int LAT_W  = 24;
    localparam int VXY_W  = 56;   // vectoring x / y
    localparam int ANG_W  = 34;   // angle, full turn = 2^32
    localparam int RXY_W  = 34;   // rotation x / y, q30
    localparam int ATAN_ENTRIES = 24;

    localparam logic [31:0] REG_FOCAL_RESET  = 32'd141889;
    localparam logic [31:0] REG_CENTER_RESET = 32'd82048;
    localparam logic signed [RXY_W-1:0] GAIN_INV_Q30 = 34'sd652032874;

    typedef enum logic {REG_FOCAL = 1'b0, REG_CENTER = 1'b1} reg_idx_t;

    typedef struct packed {
        logic [23:0]       rem;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  quo;
        logic [FWD_W-1:0]  fwd;
        logic              neg;
    } div_t;

    typedef struct packed {
        logic signed [VXY_W-1:0] x;
        logic signed [VXY_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
        logic [FWD_W-1:0]        fwd;
        logic [LAT_W-1:0]        lat;
    } vec_t;

    typedef struct packed {
        logic signed [RXY_W-1:0] x;
        logic signed [RXY_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic [FWD_W-1:0]        fwd;
        logic [LAT_W-1:0]        lat;
    } rot_t;

    function automatic logic signed [ANG_W-1:0] atan_val(input int idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/dpgp_div_cell.sv
// ----------------------------------------------------------------------------
// dpgp_div_cell
// one restoring-division step: one quotient bit per cell
// ----------------------------------------------------------------------------
module dpgp_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [23:0]   divisor,
    input  logic          in_valid,
    input  dpgp_pkg::div_t in_data,
    output logic          out_valid,
    output dpgp_pkg::div_t out_data
);
    import dpgp_pkg::*;

    logic [24:0] trial;
    logic        ge;
    div_t        data_next;
    logic        valid_reg;
    div_t        data_reg;

    always_comb
    begin
        trial = {in_data.rem, in_data.num[NUM_W-1]};
        ge    = trial >= {1'b0, divisor};
        data_next     = in_data;
        data_next.rem = ge ? 24'(trial - {1'b0, divisor}) : trial[23:0];
        data_next.num = {in_data.num[NUM_W-2:0], 1'b0};
        data_next.quo = {in_data.quo[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

>>> rtl/dpgp_vec_cell.sv
// ----------------------------------------------------------------------------
// dpgp_vec_cell
// one vectoring cordic micro-rotation
// ----------------------------------------------------------------------------
module dpgp_vec_cell #(
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  dpgp_pkg::vec_t in_data,
    output logic           out_valid,
    output dpgp_pkg::vec_t out_data
);
    import dpgp_pkg::*;

    vec_t data_next;
    vec_t data_reg;
    logic valid_reg;

    always_comb
    begin
        data_next = in_data;
        if (in_data.y >= 0)
        begin
            data_next.x = in_data.x + (in_data.y >>> IDX);
            data_next.y = in_data.y - (in_data.x >>> IDX);
            data_next.z = in_data.z + atan_val(IDX);
        end
        else
        begin
            data_next.x = in_data.x - (in_data.y >>> IDX);
            data_next.y = in_data.y + (in_data.x >>> IDX);
            data_next.z = in_data.z - atan_val(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

>>> rtl/dpgp_rot_cell.sv
// ----------------------------------------------------------------------------
// dpgp_rot_cell
// one rotation cordic micro-rotation
// ----------------------------------------------------------------------------
module dpgp_rot_cell #(
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  dpgp_pkg::rot_t in_data,
    output logic           out_valid,
    output dpgp_pkg::rot_t out_data
);
    import dpgp_pkg::*;

    rot_t data_next;
    rot_t data_reg;
    logic valid_reg;

    always_comb
    begin
        data_next = in_data;
        if (in_data.z >= 0)
        begin
            data_next.x = in_data.x - (in_data.y >>> IDX);
            data_next.y = in_data.y + (in_data.x >>> IDX);
            data_next.z = in_data.z - atan_val(IDX);
        end
        else
        begin
            data_next.x = in_data.x + (in_data.y >>> IDX);
            data_next.y = in_data.y - (in_data.x >>> IDX);
            data_next.z = in_data.z + atan_val(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

>>> rtl/depth_pixel_to_ground_pose_top.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_ground_pose_top
// pinhole deprojection of a pixel to a ground point plus heading quaternion
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle; the whole chain advances whenever the
//   output register is empty or being taken
// the pipeline depth is set by the 35-cell divider chain and the two cordic cell chains
// reset: asynchronous active-low; clears all valid bits and loads the register
//   reset values, no clearing pass
module depth_pixel_to_ground_pose_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // pixel_col[11:0], depth_q16[35:12],
                                   // robot_x_mm[59:36], robot_y_mm[83:60], zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // target_fwd_cm[14:0], target_lat_cm[38:15],
                                   // quat_z[54:39], quat_w[70:55], zero pad
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dpgp_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    // ---------------- configuration registers ----------------
    logic [23:0] focal_reg;
    logic [19:0] center_reg;
    logic [23:0] focal_eff;
    reg_idx_t    wr_idx;

    assign pready = 1'b1;
    assign wr_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= REG_FOCAL_RESET[23:0];
            center_reg <= REG_CENTER_RESET[19:0];
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (wr_idx)
                REG_FOCAL:  focal_reg  <= pwdata[23:0];
                REG_CENTER: center_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_FOCAL:  prdata = {8'd0, focal_reg};
            REG_CENTER: prdata = {12'd0, center_reg};
            default:    prdata = '0;
        endcase
    end

    // zero focal behaves as one
    assign focal_eff = (focal_reg == 24'd0) ? 24'd1 : focal_reg;

    // ---------------- flow control ----------------
    // chain moves as a whole whenever the output slot can take a result
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- input unpack ----------------
    logic [11:0]        in_col;
    logic [23:0]        in_depth;
    logic signed [23:0] in_rx;
    logic signed [23:0] in_ry;
    assign in_col   = s_tdata[11:0];
    assign in_depth = s_tdata[35:12];
    assign in_rx    = s_tdata[59:36];
    assign in_ry    = s_tdata[83:60];

    // ---------------- stage 1: column offset times depth ----------------
    logic signed [20:0] diff;
    logic [19:0]        abs_diff;
    logic [30:0]        fwd_prod;
    assign diff     = $signed({1'b0, in_col, 8'd0}) - $signed({1'b0, center_reg});
    assign abs_diff = diff[20] ? 20'(-diff) : diff[19:0];
    assign fwd_prod = 31'(in_depth) * 31'd100;

    logic        s1_valid_reg;
    logic [43:0] s1_prod_reg;
    logic [14:0] s1_fwd_reg;
    logic        s1_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= 44'(abs_diff) * 44'(in_depth);
            s1_fwd_reg  <= fwd_prod[30:16];
            // positive offset gives negative lateral
            s1_neg_reg  <= !diff[20] && (diff != 21'sd0);
        end
    end

    // ---------------- stage 2: scale by 100, form dividend ----------------
    logic [50:0] mag;
    assign mag = 51'(s1_prod_reg) * 51'd100;

    div_t div_d [0:NUM_W];
    logic div_v [0:NUM_W];
    div_t div_init;
    logic s2_valid_reg;
    div_t s2_data_reg;

    always_comb
    begin
        div_init     = '0;
        div_init.num = mag[50:16];
        div_init.fwd = s1_fwd_reg;
        div_init.neg = s1_neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_data_reg <= div_init;
    end

    assign div_d[0] = s2_data_reg;
    assign div_v[0] = s2_valid_reg;

    // ---------------- divider chain: one quotient bit per cell ----------------
    genvar gi;
    generate
        for (gi = 0; gi < NUM_W; gi++)
        begin : g_div
            dpgp_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .divisor   (focal_eff),
                .in_valid  (div_v[gi]),
                .in_data   (div_d[gi]),
                .out_valid (div_v[gi+1]),
                .out_data  (div_d[gi+1])
            );
        end
    endgenerate

    // ---------------- lateral sign and saturation ----------------
    logic [NUM_W-1:0] quo;
    logic [23:0]      lat_next;
    assign quo = div_d[NUM_W].quo;

    always_comb
    begin
        if (div_d[NUM_W].neg)
            lat_next = (quo > 35'd8388608) ? 24'h800000 : 24'(-quo);
        else
            lat_next = (quo > 35'd8388607) ? 24'h7FFFFF : quo[23:0];
    end

    logic        sl_valid_reg;
    logic [23:0] sl_lat_reg;
    logic [14:0] sl_fwd_reg;

    // robot position is needed here; it rides along a delay line of its own
    localparam int POS_DLY = NUM_W + 3;
    logic [47:0] pos_dly [0:POS_DLY-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_dly[0] <= {in_ry, in_rx};
            for (int k = 1; k < POS_DLY; k++)
                pos_dly[k] <= pos_dly[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sl_valid_reg <= 1'b0;
        else if (en)
            sl_valid_reg <= div_v[NUM_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_lat_reg <= lat_next;
            sl_fwd_reg <= div_d[NUM_W].fwd;
        end
    end

    // ---------------- vectoring setup: differences, prescale, half-plane ----------------
    logic signed [23:0] rx_d;
    logic signed [23:0] ry_d;
    logic signed [25:0] dx;
    logic signed [28:0] dy;
    logic signed [VXY_W-1:0] x0;
    logic signed [VXY_W-1:0] y0;
    vec_t vec_init;

    assign rx_d = pos_dly[POS_DLY-1][23:0];
    assign ry_d = pos_dly[POS_DLY-1][47:24];
    assign dx   = $signed({7'd0, 19'(sl_fwd_reg) * 19'd10}) - 26'(rx_d);
    assign dy   = 29'(28'(signed'(sl_lat_reg)) * 28'sd10) - 29'(ry_d);
    assign x0   = {{(VXY_W-50){dx[25]}}, dx, 24'd0};
    assign y0   = {{(VXY_W-53){dy[28]}}, dy, 24'd0};

    always_comb
    begin
        vec_init      = '0;
        vec_init.fwd  = sl_fwd_reg;
        vec_init.lat  = sl_lat_reg;
        vec_init.zero = (dx == 26'sd0) && (dy == 29'sd0);
        if (dx < 0)
        begin
            // target behind: fold into the right half-plane, start at a half turn
            vec_init.x = -x0;
            vec_init.y = -y0;
            vec_init.z = (dy >= 0) ? 34'sh080000000 : -34'sh080000000;
        end
        else
        begin
            vec_init.x = x0;
            vec_init.y = y0;
        end
    end

    vec_t vec_d [0:STEPS];
    logic vec_v [0:STEPS];
    logic sp_valid_reg;
    vec_t sp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_valid_reg <= 1'b0;
        else if (en)
            sp_valid_reg <= sl_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sp_data_reg <= vec_init;
    end

    assign vec_d[0] = sp_data_reg;
    assign vec_v[0] = sp_valid_reg;

    generate
        for (gi = 0; gi < STEPS; gi++)
        begin : g_vec
            dpgp_vec_cell #(.IDX(gi)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (vec_v[gi]),
                .in_data   (vec_d[gi]),
                .out_valid (vec_v[gi+1]),
                .out_data  (vec_d[gi+1])
            );
        end
    endgenerate

    // ---------------- rotation setup: half angle, unit vector scaled by 1/gain ----------------
    rot_t rot_d [0:STEPS];
    logic rot_v [0:STEPS];
    logic signed [ANG_W-1:0] theta;

    // robot on target gives a zero heading
    assign theta = vec_d[STEPS].zero ? '0 : vec_d[STEPS].z;

    always_comb
    begin
        rot_d[0].x   = GAIN_INV_Q30;
        rot_d[0].y   = '0;
        rot_d[0].z   = theta >>> 1;
        rot_d[0].fwd = vec_d[STEPS].fwd;
        rot_d[0].lat = vec_d[STEPS].lat;
    end
    assign rot_v[0] = vec_v[STEPS];

    generate
        for (gi = 0; gi < STEPS; gi++)
        begin : g_rot
            dpgp_rot_cell #(.IDX(gi)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (rot_v[gi]),
                .in_data   (rot_d[gi]),
                .out_valid (rot_v[gi+1]),
                .out_data  (rot_d[gi+1])
            );
        end
    endgenerate

    // ---------------- q30 to q1.15 with rounding and saturation ----------------
    function automatic logic [15:0] to_q15(input logic signed [RXY_W-1:0] v);
        logic signed [RXY_W:0]    s;
        logic signed [RXY_W-15:0] r;
        logic [15:0]              q;
        s = 35'(v) + 35'sd16384;
        r = 20'(s >>> 15);
        if (r > 20'sd32767)
            q = 16'h7FFF;
        else if (r < -20'sd32768)
            q = 16'h8000;
        else
            q = r[15:0];
        return q;
    endfunction

    // ---------------- output register ----------------
    logic [71:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= rot_v[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {1'b0, to_q15(rot_d[STEPS].x), to_q15(rot_d[STEPS].y),
                             rot_d[STEPS].lat, rot_d[STEPS].fwd};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

>>> rtl/dpgp_checker.sv
// ----------------------------------------------------------------------------
// dpgp_checker
// port-level checks on the top level, attached by bind
// ----------------------------------------------------------------------------
module dpgp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        pready
);
    // a result waiting for the sink stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty output slot never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // forward distance is bounded by full-scale depth
    a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[14:0] <= 15'd25599)
        else $error("forward distance out of range");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind depth_pixel_to_ground_pose_top dpgp_checker u_dpgp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
